>>> sv/tpma_pkg.sv
// Shared types and constants of the three-phase trimmed mean alarm core.
// No dependencies.
package tpma_pkg;

   localparam int WINDOW_LEN    = 5;
   localparam int TRIM_EACH_END = 1;
   localparam int KEPT          = WINDOW_LEN - 2 * TRIM_EACH_END;
   localparam int SLOT_W        = $clog2(WINDOW_LEN);
   localparam int MEM_DEPTH     = 3 * WINDOW_LEN;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);
   localparam int SUM_W         = 16 + $clog2(WINDOW_LEN + 1);

   // The mean divides by the kept count through a multiply by its rounded-up
   // reciprocal, exact for every sum that fits in SUM_W bits.
   localparam int KEPT_DIV    = (KEPT > 0) ? KEPT : 1;
   localparam int MEAN_SHIFT  = SUM_W + $clog2(KEPT_DIV);
   localparam int MEAN_PROD_W = SUM_W + MEAN_SHIFT + 1;
   localparam logic [MEAN_SHIFT:0] MEAN_RECIP = (MEAN_SHIFT + 1)'(
      ((64'd1 << MEAN_SHIFT) + 64'(KEPT_DIV) - 64'd1) / 64'(KEPT_DIV));

   localparam logic [15:0] SHOWN_RESET = 16'd8888;
   localparam logic [13:0] THRESH_MAX  = 14'd9999;
   localparam logic [15:0] SCALE_MAX   = 16'hFFFF;

   localparam logic [2:0] CSR_RATIO_L1   = 3'd0;
   localparam logic [2:0] CSR_RATIO_L2   = 3'd1;
   localparam logic [2:0] CSR_RATIO_L3   = 3'd2;
   localparam logic [2:0] CSR_FLOOR      = 3'd3;
   localparam logic [2:0] CSR_CEILING    = 3'd4;
   localparam logic [2:0] CSR_REFRESH    = 3'd5;
   localparam logic [2:0] CSR_BUZZ_HALF  = 3'd6;

   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic        op;
      logic [23:0] raw_rms_l1;
      logic [23:0] raw_rms_l2;
      logic [23:0] raw_rms_l3;
      logic [9:0]  setpoint_adc;
   } req_type;

   typedef struct packed {
      logic [15:0] display_l1;
      logic [15:0] display_l2;
      logic [15:0] display_l3;
      logic        alarm_l1;
      logic        alarm_l2;
      logic        alarm_l3;
      logic        buzz_drive;
      logic [13:0] threshold;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [23:0] dividend;
      logic [11:0] divisor;
   } div_cmd_type;

endpackage

>>> sv/three_phase_trimmed_mean_alarm_core.sv
// Three-phase current monitor with trimmed-mean filter and alarm.
// A request on req_ is either a timer tick or a sample round; every request
// yields exactly one response on rsp_ with the state after that request.
// Configuration registers are to be written on csr_ by the user only while
// no request is in work; the block itself does not enforce this. A tick's
// response is registered in S_FINISH. A sample round divides the three
// readings one after another on a shared bit-serial divider and writes them
// into the ring memory; while the rings fill, the response follows the last
// divide. With full rings each ring is read through the one read port, every
// entry is ranked against the others and the kept sum is scaled by a
// reciprocal multiply, ring after ring, before the response can be taken.
// After the response is taken the core returns to idle; one request is in
// work at a time.
// The response sits in an output register; while rsp_stall is high it
// holds, and req_stall stays high until the response is taken.
// Reset is synchronous and active high; it restores the register defaults,
// shows 8888 and empties the rings. Ring contents need no clearing, since
// they are read only after every slot was written.
// Depends on tpma_pkg, tpma_divider and tpma_window_ram.
module three_phase_trimmed_mean_alarm_core
   import tpma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_START, S_DIV_WAIT, S_LOAD, S_LOAD_WAIT,
      S_CMP, S_SUM, S_MEAN, S_FINISH, S_RESP
   } state_type;

   state_type    state_ff, state_in;
   req_type      req_ff, req_in;
   rsp_type      rsp_ff, rsp_in;
   logic [11:0]  ratio_ff [3];
   logic [5:0]   floor_ff, ceil_ff;
   logic [7:0]   refresh_ticks_ff;
   logic [6:0]   buzz_half_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic         full_ff, full_in;
   logic [7:0]   refresh_cnt_ff, refresh_cnt_in;
   logic [7:0]   buzz_cnt_ff, buzz_cnt_in;
   logic         buzz_ff, buzz_in;
   logic [15:0]  shown_ff [3];
   logic [15:0]  shown_in [3];
   logic [2:0]   alarm_ff, alarm_in;
   logic [13:0]  thr_ff, thr_in;
   logic [1:0]   phase_ff, phase_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [15:0]  buf_ff [WINDOW_LEN];
   logic [15:0]  buf_in [WINDOW_LEN];
   logic [SLOT_W-1:0] rank_ff, rank_in;
   logic [SLOT_W-1:0] other_ff, other_in;
   logic [SLOT_W:0]   less_ff, less_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [15:0]  mean_ff [3];
   logic [15:0]  mean_in [3];
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [SUM_W-1:0]  rem_ff, rem_in;
   logic [13:0]  prod_ff, prod_in;
   logic [22:0]  thr_mul;
   logic [14:0]  thr_sum;
   logic [MEAN_PROD_W-1:0] mean_prod;

   div_cmd_type  div_cmd;
   logic         div_done;
   logic [15:0]  div_q;
   logic         ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [15:0]  ram_wdata, ram_rdata;
   logic [5:0]   span;
   logic [SLOT_W:0] pos_lo, pos_hi;
   logic         prec;

   tpma_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_q)
   );

   tpma_window_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   assign span    = (ceil_ff >= floor_ff) ? (ceil_ff - floor_ff) : 6'd0;
   assign thr_mul = 23'(req_ff.setpoint_adc) * 23'(span) * 23'd100;
   assign thr_sum = 15'(thr_mul[22:10]) + 15'(floor_ff) * 15'd100;
   assign mean_prod = MEAN_PROD_W'(rem_ff) * MEAN_PROD_W'(MEAN_RECIP);

   // Rank order with ties broken by index reproduces a stable sort.
   assign prec = (buf_ff[other_ff] < buf_ff[rank_ff]) ||
                 ((buf_ff[other_ff] == buf_ff[rank_ff]) && (other_ff < rank_ff));
   assign pos_lo = (SLOT_W+1)'(TRIM_EACH_END);
   assign pos_hi = (SLOT_W+1)'(WINDOW_LEN - TRIM_EACH_END);

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      rsp_in         = rsp_ff;
      slot_in        = slot_ff;
      full_in        = full_ff;
      refresh_cnt_in = refresh_cnt_ff;
      buzz_cnt_in    = buzz_cnt_ff;
      buzz_in        = buzz_ff;
      shown_in       = shown_ff;
      alarm_in       = alarm_ff;
      thr_in         = thr_ff;
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      buf_in         = buf_ff;
      rank_in        = rank_ff;
      other_in       = other_ff;
      less_in        = less_ff;
      sum_in         = sum_ff;
      mean_in        = mean_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      prod_in        = prod_ff;
      div_cmd        = '0;
      ram_we         = 1'b0;
      ram_addr       = ADDR_W'(phase_ff * WINDOW_LEN) + ADDR_W'(idx_ff);
      ram_wdata      = div_q;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.op == OP_TICK) begin
                  if (refresh_cnt_ff < refresh_ticks_ff) begin
                     refresh_cnt_in = refresh_cnt_ff + 8'd1;
                  end
                  if (alarm_ff != 3'd0) begin
                     buzz_cnt_in = buzz_cnt_ff + 8'd1;
                     if (buzz_cnt_in < {1'b0, buzz_half_ff}) begin
                        buzz_in = 1'b1;
                     end else if (buzz_cnt_in < {buzz_half_ff, 1'b0}) begin
                        buzz_in = 1'b0;
                     end else begin
                        buzz_cnt_in = 8'd0;
                     end
                  end else begin
                     buzz_in = 1'b0;
                  end
                  state_in = S_FINISH;
               end else begin
                  phase_in = 2'd0;
                  state_in = S_DIV_START;
               end
            end
         end
         S_DIV_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = (phase_ff == 2'd0) ? req_ff.raw_rms_l1 :
                               (phase_ff == 2'd1) ? req_ff.raw_rms_l2 :
                                                    req_ff.raw_rms_l3;
            div_cmd.divisor  = ratio_ff[phase_ff];
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            ram_addr = ADDR_W'(phase_ff * WINDOW_LEN) + ADDR_W'(slot_ff);
            if (div_done) begin
               ram_we = 1'b1;
               if (phase_ff == 2'd2) begin
                  // The divide by 1024 keeps the upper product bits.
                  prod_in = (thr_sum > 15'(THRESH_MAX)) ? THRESH_MAX : thr_sum[13:0];
                  thr_in = prod_in;
                  if (slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
                     slot_in = '0;
                     full_in = 1'b1;
                  end else begin
                     slot_in = slot_ff + SLOT_W'(1);
                  end
                  phase_in = 2'd0;
                  idx_in   = '0;
                  if (full_ff || slot_ff == SLOT_W'(WINDOW_LEN - 1)) begin
                     state_in = S_LOAD;
                  end else begin
                     for (int p = 0; p < 3; p++) shown_in[p] = 16'd0;
                     state_in = S_FINISH;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
                  state_in = S_DIV_START;
               end
            end
         end
         S_LOAD: begin
            state_in = S_LOAD_WAIT;
         end
         S_LOAD_WAIT: begin
            buf_in[idx_ff] = ram_rdata;
            if (idx_ff == SLOT_W'(WINDOW_LEN - 1)) begin
               rank_in  = '0;
               other_in = '0;
               less_in  = '0;
               sum_in   = '0;
               state_in = S_CMP;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = S_LOAD;
            end
         end
         S_CMP: begin
            less_in = less_ff + ((SLOT_W+1)'(prec));
            if (other_ff == SLOT_W'(WINDOW_LEN - 1)) begin
               if (less_in >= pos_lo && less_in < pos_hi) begin
                  sum_in = sum_ff + SUM_W'(buf_ff[rank_ff]);
               end
               less_in  = '0;
               other_in = '0;
               if (rank_ff == SLOT_W'(WINDOW_LEN - 1)) begin
                  quo_in   = '0;
                  rem_in   = sum_in;
                  state_in = S_SUM;
               end else begin
                  rank_in = rank_ff + SLOT_W'(1);
               end
            end else begin
               other_in = other_ff + SLOT_W'(1);
            end
         end
         S_SUM: begin
            if (KEPT <= 0) begin
               quo_in = '0;
            end else begin
               quo_in = SUM_W'(mean_prod >> MEAN_SHIFT);
            end
            state_in = S_MEAN;
         end
         S_MEAN: begin
            mean_in[phase_ff] = quo_ff[15:0];
            if (phase_ff == 2'd2) begin
               if (refresh_cnt_ff == refresh_ticks_ff) begin
                  shown_in[0] = mean_ff[0];
                  shown_in[1] = mean_ff[1];
                  shown_in[2] = quo_ff[15:0];
                  refresh_cnt_in = 8'd0;
               end
               alarm_in[0] = {2'b00, thr_ff} < shown_in[0];
               alarm_in[1] = {2'b00, thr_ff} < shown_in[1];
               alarm_in[2] = {2'b00, thr_ff} < shown_in[2];
               state_in = S_FINISH;
            end else begin
               phase_in = phase_ff + 2'd1;
               idx_in   = '0;
               state_in = S_LOAD;
            end
         end
         S_FINISH: begin
            rsp_in.display_l1 = shown_ff[0];
            rsp_in.display_l2 = shown_ff[1];
            rsp_in.display_l3 = shown_ff[2];
            rsp_in.alarm_l1   = alarm_ff[0];
            rsp_in.alarm_l2   = alarm_ff[1];
            rsp_in.alarm_l3   = alarm_ff[2];
            rsp_in.buzz_drive = buzz_ff;
            rsp_in.threshold  = thr_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      phase_ff <= phase_in;
      idx_ff   <= idx_in;
      buf_ff   <= buf_in;
      rank_ff  <= rank_in;
      other_ff <= other_in;
      less_ff  <= less_in;
      sum_ff   <= sum_in;
      mean_ff  <= mean_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         ratio_ff[0]      <= 12'd728;
         ratio_ff[1]      <= 12'd1082;
         ratio_ff[2]      <= 12'd565;
         floor_ff         <= 6'd8;
         ceil_ff          <= 6'd15;
         refresh_ticks_ff <= 8'd200;
         buzz_half_ff     <= 7'd100;
         slot_ff          <= '0;
         full_ff          <= 1'b0;
         refresh_cnt_ff   <= 8'd0;
         buzz_cnt_ff      <= 8'd0;
         buzz_ff          <= 1'b0;
         shown_ff[0]      <= SHOWN_RESET;
         shown_ff[1]      <= SHOWN_RESET;
         shown_ff[2]      <= SHOWN_RESET;
         alarm_ff         <= 3'd0;
         thr_ff           <= 14'd0;
      end else begin
         state_ff       <= state_in;
         slot_ff        <= slot_in;
         full_ff        <= full_in;
         refresh_cnt_ff <= refresh_cnt_in;
         buzz_cnt_ff    <= buzz_cnt_in;
         buzz_ff        <= buzz_in;
         shown_ff       <= shown_in;
         alarm_ff       <= alarm_in;
         thr_ff         <= thr_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_RATIO_L1:  ratio_ff[0]      <= csr_wdata;
               CSR_RATIO_L2:  ratio_ff[1]      <= csr_wdata;
               CSR_RATIO_L3:  ratio_ff[2]      <= csr_wdata;
               CSR_FLOOR:     floor_ff         <= csr_wdata[5:0];
               CSR_CEILING:   ceil_ff          <= csr_wdata[5:0];
               CSR_REFRESH:   refresh_ticks_ff <= csr_wdata[7:0];
               CSR_BUZZ_HALF: buzz_half_ff     <= csr_wdata[6:0];
               default: begin
               end
            endcase
         end
      end
   end

   // A request is never taken while a response is still pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   // The shown threshold never exceeds its saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      thr_ff <= THRESH_MAX)
      else $error("threshold above limit");

   // The ring write pointer stays inside the ring.
   assert property (@(posedge clock) disable iff (reset)
      slot_ff < SLOT_W'(WINDOW_LEN))
      else $error("ring slot out of range");

endmodule

>>> sv/tpma_divider.sv
// Restoring divider, one quotient bit per cycle, saturated to 16 bits.
// Depends on tpma_pkg.
module tpma_divider
   import tpma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output logic        done,
   output logic [15:0] quotient
);

   logic [23:0] quo_ff, quo_in;
   logic [11:0] rem_ff, rem_in;
   logic [11:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [12:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[23]};
      if (cmd.start) begin
         quo_in  = cmd.dividend;
         rem_in  = '0;
         dsr_in  = cmd.divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 12'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial[11:0];
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd23) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   always_comb begin
      if (dsr_ff == 12'd0 || quo_ff[23:16] != 8'd0) begin
         quotient = SCALE_MAX;
      end else begin
         quotient = quo_ff[15:0];
      end
   end

endmodule

>>> sv/tpma_window_ram.sv
// Synchronous single-port memory holding the three phase rings.
// Depends on tpma_pkg.
module tpma_window_ram
   import tpma_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [15:0]       wr_data,
   output logic [15:0]       rd_data
);

   logic [15:0] mem [MEM_DEPTH];
   logic [15:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end

   assign rd_data = rd_ff;

endmodule
